[rtl/core/max_slot_tracker_unit_assert.svh]
// Assertion macros for the checker file of max_slot_tracker_unit.
`ifndef MAX_SLOT_TRACKER_UNIT_ASSERT_SVH
`define MAX_SLOT_TRACKER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is low.
`define MST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mst_pkg.sv]
// Shared constants, types and state codes for the max slot tracker.
`default_nettype none

package mst_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned SLOT_AW    = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);

  localparam int unsigned SLOT_IDX_W = 8;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned LEN_W      = 21;
  localparam int unsigned RND_W      = 32;
  localparam int unsigned ENTRY_W    = 9;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned DIV_CNT_W  = $clog2(RND_W);

  localparam int unsigned ROLL_MOD   = 100;
  localparam int unsigned ROLL_W     = $clog2(ROLL_MOD);

  // floor(x / 100) == (x * ceil(2^37 / 100)) >> 37 for any 32-bit x
  localparam logic [RND_W-1:0] ROLL_RECIP = 32'h51EB_851F;
  localparam int unsigned      ROLL_SHIFT = 37;
  localparam int unsigned      QUO_W      = 2 * RND_W - ROLL_SHIFT;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET  = LEN_W'(512);
  localparam logic [PCT_W-1:0] SKIP_PCT_RESET = PCT_W'(20);

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_PICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PCT = 1'b1;

  typedef struct packed {
    logic             stored;
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] max;
  } slot_entry_t;

  localparam int unsigned ENTRY_BITS = $bits(slot_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS,
    ST_DIV,
    ST_SCAN,
    ST_EMPTY
  } state_e;

endpackage

`default_nettype wire

[rtl/core/mst_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module mst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/max_slot_tracker_unit.sv]
// Max slot tracker top level: slot table RAM, count, pick sequencer, output register.
`default_nettype none

// An observe beat reads the slot entry from the table RAM at the accept edge; once
// the output register is free, ST_OBS modifies the entry, writes it back if it
// changes and registers the result. A pick beat runs a bit-serial remainder of
// random_pick by the count (random_roll mod 100 is taken by a reciprocal multiply
// during that division), then walks the per-slot valid bits one slot a cycle until
// it reaches the chosen nonzero slot, where the result is registered once the
// output register is free. A pick with an empty table answers through ST_EMPTY.
// One beat is in work at a time; the next is accepted once the result has moved
// to the output register, so a result held by out_ready_i stalls the input too.
// A flip-flop per slot marks entries written since reset, so the table needs no
// clearing pass and is usable right after reset. Configuration is to be written
// through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not enforce it.

module max_slot_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [mst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mst_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [mst_pkg::SLOT_IDX_W-1:0]   slot_index_i,
  input  logic [mst_pkg::VAL_W-1:0]        observed_max_i,
  input  logic [mst_pkg::LEN_W-1:0]        input_length_i,
  input  logic [mst_pkg::RND_W-1:0]        random_pick_i,
  input  logic [mst_pkg::RND_W-1:0]        random_roll_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             store_input_o,
  output logic                             new_slot_o,
  output logic                             minimized_o,
  output logic                             previously_stored_o,
  output logic [mst_pkg::ENTRY_W-1:0]      entry_count_o,
  output logic                             schedule_go_o,
  output logic [mst_pkg::SLOT_IDX_W-1:0]   picked_slot_o,
  output logic                             pick_valid_o
);

  import mst_pkg::*;

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SLOTS-1:0]   slot_vld_q, slot_vld_d;
  logic               out_valid_q, out_valid_d;
  logic [LEN_W-1:0]   min_len_q;
  logic [PCT_W-1:0]   skip_pct_q;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [SLOT_AW-1:0] scan_q, scan_d;

  // working payload
  logic [SLOT_AW-1:0] addr_q, addr_d;
  logic               in_range_q, in_range_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [RND_W-1:0]   pick_sh_q, pick_sh_d;
  logic [RND_W-1:0]   roll_q, roll_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [ROLL_W-1:0]  mod_q, mod_d;

  // result register
  logic                  res_store_q, res_store_d;
  logic                  res_new_q, res_new_d;
  logic                  res_mini_q, res_mini_d;
  logic                  res_prev_q, res_prev_d;
  logic [ENTRY_W-1:0]    res_count_q, res_count_d;
  logic                  res_go_q, res_go_d;
  logic [SLOT_IDX_W-1:0] res_slot_q, res_slot_d;
  logic                  res_pvalid_q, res_pvalid_d;

  // table RAM
  logic               ram_we, ram_re;
  logic [SLOT_AW-1:0] ram_raddr;
  slot_entry_t        ram_wdata, ram_rdata;

  logic               accept, out_free, load;
  logic               cur_vld;
  slot_entry_t        cur;
  logic               raise, tie, upd;
  logic [CNT_W:0]     rem_sh;
  logic [2*RND_W-1:0] roll_prod;
  logic [RND_W-1:0]   roll_rem;
  logic               hit;

  mst_ram #(
    .Width(ENTRY_BITS),
    .Depth(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign ram_raddr  = SLOT_AW'(slot_index_i);

  // an entry never written reads as zero
  assign cur_vld = slot_vld_q[addr_q];
  assign cur     = cur_vld ? ram_rdata : '0;
  assign raise   = in_range_q && (val_q > cur.max);
  assign tie     = in_range_q && (len_q > min_len_q) && (val_q == cur.max)
                   && (len_q < cur.len);
  assign upd     = raise || tie;

  assign ram_wdata.stored = 1'b1;
  assign ram_wdata.len    = len_q;
  assign ram_wdata.max    = raise ? val_q : cur.max;

  assign rem_sh    = {rem_q, pick_sh_q[RND_W-1]};
  assign roll_prod = (2*RND_W)'(roll_q) * (2*RND_W)'(ROLL_RECIP);
  assign roll_rem  = roll_q - RND_W'(quo_q) * RND_W'(ROLL_MOD);
  assign hit       = slot_vld_q[scan_q];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    slot_vld_d   = slot_vld_q;
    div_cnt_d    = div_cnt_q;
    scan_d       = scan_q;
    addr_d       = addr_q;
    in_range_d   = in_range_q;
    val_d        = val_q;
    len_d        = len_q;
    pick_sh_d    = pick_sh_q;
    roll_d       = roll_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    mod_d        = mod_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    load         = 1'b0;
    res_store_d  = 1'b0;
    res_new_d    = 1'b0;
    res_mini_d   = 1'b0;
    res_prev_d   = 1'b0;
    res_go_d     = 1'b0;
    res_slot_d   = '0;
    res_pvalid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d     = SLOT_AW'(slot_index_i);
          in_range_d = (32'(slot_index_i) < SLOTS);
          val_d      = observed_max_i;
          len_d      = input_length_i;
          pick_sh_d  = random_pick_i;
          roll_d     = random_roll_i;
          rem_d      = '0;
          mod_d      = '0;
          div_cnt_d  = DIV_CNT_W'(RND_W - 1);
          scan_d     = '0;
          if (command_i == CMD_OBSERVE) begin
            ram_re  = 1'b1;
            state_d = ST_OBS;
          end else if (count_q == '0) begin
            state_d = ST_EMPTY;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_OBS: begin
        if (out_free) begin
          load        = 1'b1;
          ram_we      = upd;
          res_store_d = upd;
          res_mini_d  = tie && !raise;
          res_prev_d  = upd && cur.stored;
          if (raise && (cur.max == '0)) begin
            count_d   = count_q + 1'b1;
            res_new_d = 1'b1;
          end
          if (upd) begin
            slot_vld_d[addr_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle for the pick remainder
        rem_d = (rem_sh >= {1'b0, count_q}) ? CNT_W'(rem_sh - {1'b0, count_q})
                                            : CNT_W'(rem_sh);
        // roll quotient is registered, then its remainder is taken from it; both settle before the scan
        quo_d     = roll_prod[2*RND_W-1:ROLL_SHIFT];
        mod_d     = ROLL_W'(roll_rem);
        pick_sh_d = pick_sh_q << 1;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit && (rem_q == '0)) begin
          if (out_free) begin
            load         = 1'b1;
            res_go_d     = ({1'b0, mod_q} > (PCT_W + 1)'(skip_pct_q));
            res_slot_d   = SLOT_IDX_W'(scan_q);
            res_pvalid_d = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          if (hit) begin
            rem_d = rem_q - 1'b1;
          end
          scan_d = scan_q + 1'b1;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_count_d = ENTRY_W'(count_d);
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      scan_q      <= '0;
      min_len_q   <= MIN_LEN_RESET;
      skip_pct_q  <= SKIP_PCT_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      slot_vld_q  <= slot_vld_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
      scan_q      <= scan_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_LEN:  min_len_q  <= cfg_data_i[LEN_W-1:0];
          CFG_SKIP_PCT: skip_pct_q <= cfg_data_i[PCT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    in_range_q <= in_range_d;
    val_q      <= val_d;
    len_q      <= len_d;
    pick_sh_q  <= pick_sh_d;
    roll_q     <= roll_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    mod_q      <= mod_d;
    if (load) begin
      res_store_q  <= res_store_d;
      res_new_q    <= res_new_d;
      res_mini_q   <= res_mini_d;
      res_prev_q   <= res_prev_d;
      res_count_q  <= res_count_d;
      res_go_q     <= res_go_d;
      res_slot_q   <= res_slot_d;
      res_pvalid_q <= res_pvalid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign store_input_o       = res_store_q;
  assign new_slot_o          = res_new_q;
  assign minimized_o         = res_mini_q;
  assign previously_stored_o = res_prev_q;
  assign entry_count_o       = res_count_q;
  assign schedule_go_o       = res_go_q;
  assign picked_slot_o       = res_slot_q;
  assign pick_valid_o        = res_pvalid_q;

endmodule

`default_nettype wire

[rtl/core/mst_checker.sv]
// Port-level checker for max_slot_tracker_unit and its bind.
`default_nettype none

`include "max_slot_tracker_unit_assert.svh"

module mst_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             store_input_o,
  input logic                             new_slot_o,
  input logic                             minimized_o,
  input logic                             previously_stored_o,
  input logic [mst_pkg::ENTRY_W-1:0]      entry_count_o,
  input logic                             schedule_go_o,
  input logic [mst_pkg::SLOT_IDX_W-1:0]   picked_slot_o,
  input logic                             pick_valid_o
);

  // a stalled result beat stays valid and keeps its picked slot and entry count
  `MST_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(picked_slot_o) && $stable(entry_count_o), "output beat changed while stalled")

  // one beat in work at a time
  `MST_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "accepted a beat while busy")

  // observe and pick flags never mix in one result
  `MST_ASSERT(a_kind_exclusive, clk_i, rst_ni, out_valid_o && (store_input_o || new_slot_o || minimized_o || previously_stored_o) |-> !schedule_go_o && !pick_valid_o, "observe and pick flags mixed")

  // a fresh slot is a raise, never a minimize
  `MST_ASSERT(a_new_is_raise, clk_i, rst_ni, out_valid_o && new_slot_o |-> store_input_o && !minimized_o && !previously_stored_o, "bad new slot flags")

  // scheduling implies a slot was found
  `MST_ASSERT_ALWAYS(a_go_has_slot, clk_i, out_valid_o && schedule_go_o |-> pick_valid_o, "go without a picked slot")

endmodule

bind max_slot_tracker_unit mst_checker u_mst_checker (.*);

`default_nettype wire
